// File: rtl/core/bcu_pkg.sv
`default_nettype none

package bcu_pkg;

    localparam int MAX_N   = 20;
    localparam int N_W     = 5;
    localparam int COEF_W  = 18;
    localparam int ACC_W   = 64;
    localparam int CNT_W   = $clog2(ACC_W + 1);

    // saturate an operand to the supported range
    function automatic logic [N_W-1:0] clamp_operand(input logic [N_W-1:0] v);
        logic [N_W-1:0] lim;
        lim = N_W'(MAX_N);
        return (v > lim) ? lim : v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/binomial_coefficient_unit.sv
// Sequence: an accepted request runs the falling product, then r factorial (r
//   after saturation), then a restoring division; r above n goes to S_DONE.
// Requests: one at a time, none is taken before the last is done; req_stall
//   stays high until the result has moved into the output register, which can
//   hold while a new request runs.
// Reset: rst_n is asynchronous, active low; sequencer returns to idle and the
//   output register is emptied. Datapath registers are not reset.
`default_nettype none

module binomial_coefficient_unit
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic [bcu_pkg::N_W-1:0]    n_total,
    input  wire logic [bcu_pkg::N_W-1:0]    r_chosen,
    output logic                            res_valid,
    input  wire logic                       res_stall,
    output logic [bcu_pkg::COEF_W-1:0]      coefficient
);
    import bcu_pkg::*;

    // Sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;  // wait for a request
    localparam logic [2:0] S_PROD = 3'd1;  // falling product n(n-1)...(n-r+1)
    localparam logic [2:0] S_FACT = 3'd2;  // r factorial
    localparam logic [2:0] S_DIV  = 3'd3;  // restoring division, one bit a cycle
    localparam logic [2:0] S_DONE = 3'd4;  // hand quotient to output register

    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(ACC_W);

    logic [2:0]         state_reg, state_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;     // multiplier accumulator, later divisor
    logic [ACC_W-1:0]   num_reg, num_next;     // dividend, shifted into quotient
    logic [ACC_W-1:0]   rem_reg, rem_next;     // partial remainder
    logic [N_W-1:0]     term_reg, term_next;   // next factor of the falling product
    logic [N_W-1:0]     r_reg, r_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               res_valid_reg, res_valid_next;
    logic [COEF_W-1:0]  coef_reg, coef_next;

    logic [N_W-1:0]     n_sat;
    logic [N_W-1:0]     r_sat;
    logic [N_W-1:0]     mul_factor;
    logic [ACC_W-1:0]   mul_out;
    logic [ACC_W:0]     trial;
    logic               req_take;
    logic               out_free;

    assign n_sat    = clamp_operand(n_total);
    assign r_sat    = clamp_operand(r_chosen);
    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !res_valid_reg || !res_stall;

    // The one shared multiplier: falling-product term in PROD, counter in FACT.
    // Both products stay below 2^64 for operands up to the supported maximum.
    assign mul_factor = (state_reg == S_PROD) ? term_reg : cnt_reg[N_W-1:0];
    assign mul_out    = acc_reg * ACC_W'(mul_factor);

    // One restoring-division step: shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, num_reg[ACC_W-1]} - {1'b0, acc_reg};

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        term_next      = term_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        coef_next      = coef_reg;

        // drop the result once it has been taken
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    if (r_sat > n_sat)
                    begin
                        // nothing to compute: coefficient is zero
                        num_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        term_next  = n_sat;
                        r_next     = r_sat;
                        cnt_next   = CNT_W'(r_sat);
                        acc_next   = ACC_W'(1);
                        state_next = S_PROD;
                    end
                end
            end

            S_PROD:
            begin
                if (cnt_reg == '0)
                begin
                    // park the numerator and restart the accumulator for r!
                    num_next   = acc_reg;
                    acc_next   = ACC_W'(1);
                    cnt_next   = CNT_W'(r_reg);
                    state_next = S_FACT;
                end
                else
                begin
                    acc_next  = mul_out;
                    term_next = term_reg - N_W'(1);
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
            end

            S_FACT:
            begin
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = DIV_STEPS;
                    state_next = S_DIV;
                end
                else
                begin
                    acc_next = mul_out;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end

            S_DIV:
            begin
                if (!trial[ACC_W])
                begin
                    rem_next = trial[ACC_W-1:0];
                    num_next = {num_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[ACC_W-2:0], num_reg[ACC_W-1]};
                    num_next = {num_reg[ACC_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    coef_next      = num_reg[COEF_W-1:0];
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        term_reg <= term_next;
        r_reg    <= r_next;
        cnt_reg  <= cnt_next;
        coef_reg <= coef_next;
    end

    assign res_valid   = res_valid_reg;
    assign coefficient = coef_reg;

    // An accepted request always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // Partial remainder stays below the divisor throughout the division
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < acc_reg))
        else $error("division remainder not below divisor");

    // Factorial accumulator never wraps to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FACT) |-> (acc_reg != '0))
        else $error("factorial accumulator is zero");

    // Final quotient fits the result field
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (num_reg[ACC_W-1:COEF_W] == '0))
        else $error("quotient exceeds result width");

endmodule

`default_nettype wire
